### hdl/crdg_pkg.sv
// ----------------------------------------------------------------------------
// crdg_pkg: shared types and constants for the camera ray direction generator
// Datapath widths of the normalize chain, sized for the widest coordinate.
// ----------------------------------------------------------------------------
package crdg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_EYE      = 3'd0;
    localparam logic [2:0] REG_LL       = 3'd1;
    localparam logic [2:0] REG_LR       = 3'd2;
    localparam logic [2:0] REG_UL       = 3'd3;
    localparam logic [2:0] REG_UR       = 3'd4;
    localparam int         NUM_REGS     = 5;
    localparam int         REG_W        = 63;

    // normalize chain widths (fit coordinates up to 21 bits)
    localparam int MAG_W = 22;             // |d| component on the grid
    localparam int S_W   = 2 * MAG_W + 2;  // squared length
    localparam int D_W   = 84;             // remainder of the root test
    localparam int XS_W  = 64;             // (2k-1) * s
    localparam int K_W   = 17;             // result magnitude, up to 65536
    localparam int K_SH  = 34;             // 2^34 scale of the target

    typedef struct packed {
        logic signed [D_W-1:0]  rem;
        logic signed [XS_W-1:0] xs;
        logic [K_W-1:0]         k;
        logic                   neg;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]    lane;
        logic [S_W-1:0] s;
        logic           zero;
    } cell_t;

endpackage

### hdl/crdg_front.sv
// ----------------------------------------------------------------------------
// crdg_front: blend, eye offset, grid rounding and squared length
// Six registered stages; each stage loads when its enable is high.
// ----------------------------------------------------------------------------
module crdg_front
    import crdg_pkg::*;
#(
    parameter int COORD_WIDTH  = 21,
    parameter int UV_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic [5:0]         en,
    input  logic [16:0]        u_coord,
    input  logic [16:0]        v_coord,
    input  logic [REG_W-1:0]   eye,
    input  logic [REG_W-1:0]   ll,
    input  logic [REG_W-1:0]   lr,
    input  logic [REG_W-1:0]   ul,
    input  logic [REG_W-1:0]   ur,
    output cell_t              cell_out
);

    localparam int C  = COORD_WIDTH;
    localparam int F  = UV_FRAC_BITS;
    localparam int UW = (F + 1 > 17) ? F + 1 : 17;
    localparam int PW = C + F + 2;       // row blend
    localparam int FW = 2 * F + C + 2;   // full-precision offset
    localparam int MW = C + 1;           // grid magnitude

    // stage 0: saturated u, v
    logic [UW-1:0] one_w, u_ext, v_ext;
    logic [F:0]    us_next, vs_next, us_reg, vs_reg, vs1_reg;

    always_comb
    begin
        one_w   = UW'(1) << F;
        u_ext   = UW'(u_coord);
        v_ext   = UW'(v_coord);
        us_next = (u_ext > one_w) ? one_w[F:0] : u_ext[F:0];
        vs_next = (v_ext > one_w) ? one_w[F:0] : v_ext[F:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            us_reg <= us_next;
            vs_reg <= vs_next;
        end
    end

    // stage 1: horizontal blend of bottom and top rows
    logic [F:0]             omu;
    logic signed [PW-1:0]   rb_next [3], rt_next [3], rb_reg [3], rt_reg [3];

    always_comb
    begin
        omu = (F+1)'(1) << F;
        omu = omu - us_reg;
        for (int a = 0; a < 3; a++)
        begin
            rb_next[a] = $signed({1'b0, omu}) * $signed(ll[a*C +: C])
                       + $signed({1'b0, us_reg}) * $signed(lr[a*C +: C]);
            rt_next[a] = $signed({1'b0, omu}) * $signed(ul[a*C +: C])
                       + $signed({1'b0, us_reg}) * $signed(ur[a*C +: C]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rb_reg  <= rb_next;
            rt_reg  <= rt_next;
            vs1_reg <= vs_reg;
        end
    end

    // stage 2: vertical blend minus scaled eye
    logic [F:0]           omv;
    logic signed [FW-1:0] full_next [3], full_reg [3];

    always_comb
    begin
        omv = (F+1)'(1) << F;
        omv = omv - vs1_reg;
        for (int a = 0; a < 3; a++)
        begin
            full_next[a] = $signed({1'b0, omv}) * rb_reg[a]
                         + $signed({1'b0, vs1_reg}) * rt_reg[a]
                         - (FW'($signed(eye[a*C +: C])) <<< (2 * F));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            full_reg <= full_next;
    end

    // stage 3: round to the grid, halves away from zero
    logic [FW-1:0] abs_v [3], rnd_v [3];
    logic [MW-1:0] mag_next [3], mag_reg [3];
    logic [2:0]    neg_next, neg_reg, neg4_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            neg_next[a] = full_reg[a][FW-1];
            abs_v[a]    = neg_next[a] ? FW'(-full_reg[a]) : FW'(full_reg[a]);
            rnd_v[a]    = abs_v[a] + (FW'(1) << (2 * F - 1));
            mag_next[a] = MW'(rnd_v[a] >> (2 * F));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    // stage 4: squares
    logic [2*MW-1:0] sq_next [3], sq_reg [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            sq_next[a] = (2*MW)'(mag_reg[a]) * (2*MW)'(mag_reg[a]);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sq_reg   <= sq_next;
            neg4_reg <= neg_reg;
        end
    end

    // stage 5: squared length and chain seed (k = 0, so 2k-1 = -1)
    logic [S_W-1:0] s_v;
    cell_t          seed_next, seed_reg;

    always_comb
    begin
        s_v = S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);
        seed_next.s    = s_v;
        seed_next.zero = (s_v == '0);
        for (int a = 0; a < 3; a++)
        begin
            seed_next.lane[a].rem = ($signed(D_W'(sq_reg[a])) <<< K_SH)
                                    - $signed(D_W'(s_v));
            seed_next.lane[a].xs  = -$signed(XS_W'(s_v));
            seed_next.lane[a].k   = '0;
            seed_next.lane[a].neg = neg4_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            seed_reg <= seed_next;
    end

    assign cell_out = seed_reg;

endmodule

### hdl/crdg_cell.sv
// ----------------------------------------------------------------------------
// crdg_cell: one result bit of the unit-vector root search
// Tests k | 2^BIT on all three lanes and passes the updated state on.
// ----------------------------------------------------------------------------
module crdg_cell
    import crdg_pkg::*;
#(
    parameter int BIT = 16
)
(
    input  logic  clk,
    input  logic  en,
    input  cell_t c_in,
    output cell_t c_out
);

    cell_t c_next, c_reg;
    logic signed [D_W-1:0] need [3];
    logic signed [D_W-1:0] s_ext;
    logic [2:0]            take;

    always_comb
    begin
        c_next = c_in;
        s_ext  = $signed({{(D_W-S_W){1'b0}}, c_in.s});
        for (int a = 0; a < 3; a++)
        begin
            // (x + 2^(BIT+1))^2 s - x^2 s, x = 2k-1
            need[a] = (D_W'(c_in.lane[a].xs) <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
            take[a] = !c_in.lane[a].k[K_W-1] && (need[a] <= c_in.lane[a].rem);
            if (take[a])
            begin
                c_next.lane[a].rem = c_in.lane[a].rem - need[a];
                c_next.lane[a].xs  = c_in.lane[a].xs + XS_W'(s_ext <<< (BIT + 1));
                c_next.lane[a].k   = c_in.lane[a].k | (K_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    assign c_out = c_reg;

endmodule

### hdl/camera_ray_direction_generator.sv
// ----------------------------------------------------------------------------
// camera_ray_direction_generator: pinhole camera ray direction unit
// One beat per cycle from input beat to output beat while in_stall is low.
// Six front stages blend, round and square; 17 root cells find each bit.
// The cell chain is fully pipelined: no loop is shared.
// rst_n clears pipeline valids and all five configuration registers.
// ----------------------------------------------------------------------------
module camera_ray_direction_generator
    import crdg_pkg::*;
#(
    parameter int COORD_WIDTH  = 21,
    parameter int UV_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [16:0]        u_coord,
    input  logic [16:0]        v_coord,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] dir_x,
    output logic signed [17:0] dir_y,
    output logic signed [17:0] dir_z,
    output logic               zero_direction
);

    localparam int NF = 6;          // front stages
    localparam int NS = NF + K_W + 1; // plus cells and output stage

    // ---- configuration registers ----
    logic [REG_W-1:0] cfg_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we && (cfg_index < 3'(NUM_REGS)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // ---- pipeline flow control ----
    // A stage loads when it is empty or its contents move on; bubbles
    // collapse so the input keeps flowing while an output beat waits.
    logic [NS-1:0] v_reg, v_next, en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NS; i++)
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    // ---- front: blend, offset, round, square ----
    cell_t chain [K_W+1];

    crdg_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .en       (en[NF-1:0]),
        .u_coord  (u_coord),
        .v_coord  (v_coord),
        .eye      (cfg_reg[REG_EYE]),
        .ll       (cfg_reg[REG_LL]),
        .lr       (cfg_reg[REG_LR]),
        .ul       (cfg_reg[REG_UL]),
        .ur       (cfg_reg[REG_UR]),
        .cell_out (chain[0])
    );

    // ---- root cells, most significant bit first ----
    for (genvar g = 0; g < K_W; g++)
    begin : g_cell
        crdg_cell #(
            .BIT (K_W - 1 - g)
        ) u_cell (
            .clk   (clk),
            .en    (en[NF+g]),
            .c_in  (chain[g]),
            .c_out (chain[g+1])
        );
    end

    // ---- output stage: sign and zero-vector forcing ----
    logic signed [17:0] dir_next [3], dir_reg [3];
    logic               zero_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (chain[K_W].zero)
                dir_next[a] = '0;
            else if (chain[K_W].lane[a].neg)
                dir_next[a] = -$signed({1'b0, chain[K_W].lane[a].k});
            else
                dir_next[a] = $signed({1'b0, chain[K_W].lane[a].k});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            dir_reg  <= dir_next;
            zero_reg <= chain[K_W].zero;
        end
    end

    assign dir_x          = dir_reg[0];
    assign dir_y          = dir_reg[1];
    assign dir_z          = dir_reg[2];
    assign zero_direction = zero_reg;

endmodule
